FILE: rtl/mrnr_pkg.sv
// Shared constants, widths and helpers of the mask rasterize / nearest resize block.
`default_nettype none
package mrnr_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // coordinate and size widths
  localparam int unsigned MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned CW      = $clog2(MAX_DIM);
  localparam int unsigned SZW     = CW + 1;
  localparam int unsigned PROD_W  = 2 * CW;
  localparam int unsigned DEN_W   = CW + 1;
  localparam int unsigned NUM_W   = 2 * CW + 1;
  localparam int unsigned CNT_W   = $clog2(CW + 1);

  // bitmap storage
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WSEL_W    = $clog2(WORD_BITS);
  localparam int unsigned WORDS     = (MAX_WIDTH * MAX_HEIGHT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BIT_AW    = WORD_AW + WSEL_W;

  // field widths
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned PT_W    = 12;
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [MASK_W-1:0] MASK_ON = 8'd255;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PAINT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_TGT_W = 2'd2;
  localparam logic [1:0] REG_TGT_H = 2'd3;

  localparam logic [CFG_W-1:0] RST_SRC_W = 11'd640;
  localparam logic [CFG_W-1:0] RST_SRC_H = 11'd480;
  localparam logic [CFG_W-1:0] RST_TGT_W = 11'd640;
  localparam logic [CFG_W-1:0] RST_TGT_H = 11'd480;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [CW-1:0]    coord_t;
  typedef logic [SZW-1:0]   size_t;

  // zero reads as 1, anything above the maximum saturates
  function automatic size_t clamp_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
    size_t r;
    if (v == '0) begin
      r = SZW'(1);
    end else if (32'(v) > maxv) begin
      r = SZW'(maxv);
    end else begin
      r = SZW'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mrnr_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module mrnr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                            wdata,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/mrnr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module mrnr_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire mrnr_pkg::num_t  num,
  input  wire mrnr_pkg::den_t  den,
  output logic                 done,
  output mrnr_pkg::coord_t     quo
);
  import mrnr_pkg::*;

  num_t             rem_r, rem_nxt;
  num_t             dv_r, dv_nxt;
  coord_t           q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             ge;

  assign ge = (rem_r >= dv_r);

  always_comb begin
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dv_nxt   = NUM_W'(den) << (CW - 1);
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(CW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dv_r;
      end
      q_nxt   = CW'({q_r, ge});
      dv_nxt  = dv_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

FILE: rtl/mask_rasterize_nearest_resize_unit.sv
// Mask bitmap with nearest-neighbor resize on read: top level.
//
// Holds a 1-bit mask at source resolution in a 32-bit-wide single-port RAM.
// After reset and after every clear transaction the block sweeps the RAM, one
// word per cycle, with in_stall high; configuration writes are taken throughout.
// A paint does a word read, then a read-modify-write. A read runs each axis
// through one shared multiplier and one shared iterative divider giving one
// quotient bit per cycle; out-of-frame reads skip both. One transaction is
// processed at a time; the result register lets the next transaction start
// while the previous result waits on out_stall.
`default_nettype none
module mask_rasterize_nearest_resize_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mrnr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mrnr_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mrnr_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mrnr_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [mrnr_pkg::PT_W-1:0]     in_point_x,
  input  wire logic [mrnr_pkg::PT_W-1:0]     in_point_y,
  input  wire logic [mrnr_pkg::PIX_W-1:0]    in_pixel_x,
  input  wire logic [mrnr_pkg::PIX_W-1:0]    in_pixel_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [mrnr_pkg::MASK_W-1:0]   out_mask_value,
  output logic                               out_out_of_frame
);
  import mrnr_pkg::*;

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] S_CLR  = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE = 4'd1;
  localparam logic [ST_W-1:0] S_PRD  = 4'd2;
  localparam logic [ST_W-1:0] S_PWR  = 4'd3;
  localparam logic [ST_W-1:0] S_MUL  = 4'd4;
  localparam logic [ST_W-1:0] S_DIVS = 4'd5;
  localparam logic [ST_W-1:0] S_DIVW = 4'd6;
  localparam logic [ST_W-1:0] S_ADDR = 4'd7;
  localparam logic [ST_W-1:0] S_RRD  = 4'd8;
  localparam logic [ST_W-1:0] S_RCHK = 4'd9;
  localparam logic [ST_W-1:0] S_FIN  = 4'd10;

  // configuration
  logic [CFG_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RST_SRC_W;
      src_h_r <= RST_SRC_H;
      tgt_w_r <= RST_TGT_W;
      tgt_h_r <= RST_TGT_H;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SRC_W: src_w_r <= pwdata[CFG_W-1:0];
        REG_SRC_H: src_h_r <= pwdata[CFG_W-1:0];
        REG_TGT_W: tgt_w_r <= pwdata[CFG_W-1:0];
        REG_TGT_H: tgt_h_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SRC_W: prdata = PDATA_W'(src_w_r);
      REG_SRC_H: prdata = PDATA_W'(src_h_r);
      REG_TGT_W: prdata = PDATA_W'(tgt_w_r);
      REG_TGT_H: prdata = PDATA_W'(tgt_h_r);
      default:   prdata = '0;
    endcase
  end

  size_t sw, sh, tw, th;
  assign sw = clamp_size(src_w_r, MAX_WIDTH);
  assign sh = clamp_size(src_h_r, MAX_HEIGHT);
  assign tw = clamp_size(tgt_w_r, MAX_WIDTH);
  assign th = clamp_size(tgt_h_r, MAX_HEIGHT);

  // sequencer state
  logic [ST_W-1:0]      state_r, state_nxt;
  logic [WORD_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [WORD_AW-1:0]   waddr_r, waddr_nxt;
  logic [WSEL_W-1:0]    bsel_r, bsel_nxt;
  logic [PIX_W-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic                 axis_r, axis_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  coord_t               xs_r, xs_nxt, ys_r, ys_nxt;
  logic                 val_r, val_nxt;
  logic                 oof_r, oof_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]    out_mask_r, out_mask_nxt;
  logic                 out_oof_r, out_oof_nxt;

  // shared datapath
  size_t              s_sel, t_sel;
  coord_t             d_cw, sm1, tm1;
  logic [PROD_W-1:0]  mul_res;
  num_t               div_num;
  den_t               div_den;
  logic               div_start, div_done;
  coord_t             div_quo;
  logic               degen;
  logic [BIT_AW-1:0]  paint_addr, read_addr;
  logic               paint_ok, read_oof, in_acc, out_free;

  logic                 ram_we;
  logic [WORD_AW-1:0]   ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  assign s_sel   = axis_r ? sh : sw;
  assign t_sel   = axis_r ? th : tw;
  assign d_cw    = CW'(axis_r ? dy_r : dx_r);
  assign sm1     = CW'(s_sel - SZW'(1));
  assign tm1     = CW'(t_sel - SZW'(1));
  assign mul_res = PROD_W'(d_cw) * PROD_W'(sm1);
  assign div_num = NUM_W'({prod_r, 1'b0}) + NUM_W'(tm1);
  assign div_den = DEN_W'({tm1, 1'b0});
  assign degen   = (s_sel < SZW'(2)) || (t_sel < SZW'(2));

  assign paint_addr = BIT_AW'(BIT_AW'(in_point_y) * BIT_AW'(MAX_WIDTH) + BIT_AW'(in_point_x));
  assign read_addr  = BIT_AW'(BIT_AW'(ys_r) * BIT_AW'(MAX_WIDTH) + BIT_AW'(xs_r));
  assign paint_ok   = (32'(in_point_x) < 32'(sw)) && (32'(in_point_y) < 32'(sh));
  assign read_oof   = (32'(in_pixel_x) >= 32'(tw)) || (32'(in_pixel_y) >= 32'(th));

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    waddr_nxt     = waddr_r;
    bsel_nxt      = bsel_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    axis_nxt      = axis_r;
    prod_nxt      = prod_r;
    xs_nxt        = xs_r;
    ys_nxt        = ys_r;
    val_nxt       = val_r;
    oof_nxt       = oof_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_mask_nxt  = out_mask_r;
    out_oof_nxt   = out_oof_r;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = waddr_r;
    ram_wdata     = ram_rdata | (WORD_BITS'(1) << bsel_r);

    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_r;
        ram_wdata = '0;
        if (32'(clr_cnt_r) == WORDS - 1) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + WORD_AW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLR;
            end
            REQ_PAINT: begin
              if (paint_ok) begin
                waddr_nxt = paint_addr[BIT_AW-1:WSEL_W];
                bsel_nxt  = paint_addr[WSEL_W-1:0];
                state_nxt = S_PRD;
              end
            end
            REQ_READ: begin
              dx_nxt   = in_pixel_x;
              dy_nxt   = in_pixel_y;
              axis_nxt = 1'b0;
              val_nxt  = 1'b0;
              oof_nxt  = read_oof;
              state_nxt = read_oof ? S_FIN : S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_PRD: begin
        state_nxt = S_PWR;
      end
      S_PWR: begin
        ram_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        prod_nxt  = mul_res;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          if (axis_r) begin
            ys_nxt    = degen ? '0 : div_quo;
            state_nxt = S_ADDR;
          end else begin
            xs_nxt    = degen ? '0 : div_quo;
            axis_nxt  = 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_ADDR: begin
        waddr_nxt = read_addr[BIT_AW-1:WSEL_W];
        bsel_nxt  = read_addr[WSEL_W-1:0];
        state_nxt = S_RRD;
      end
      S_RRD: begin
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        val_nxt   = ram_rdata[bsel_r];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = val_r ? MASK_ON : '0;
          out_oof_nxt   = oof_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    waddr_r    <= waddr_nxt;
    bsel_r     <= bsel_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    axis_r     <= axis_nxt;
    prod_r     <= prod_nxt;
    xs_r       <= xs_nxt;
    ys_r       <= ys_nxt;
    val_r      <= val_nxt;
    oof_r      <= oof_nxt;
    out_mask_r <= out_mask_nxt;
    out_oof_r  <= out_oof_nxt;
  end

  mrnr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  mrnr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_mask_value   = out_mask_r;
  assign out_out_of_frame = out_oof_r;

endmodule
`default_nettype wire

FILE: bench/tb_mask_rasterize_nearest_resize_unit.sv
// Testbench of the mask rasterize / nearest resize unit: directed and random transactions.
module tb_mask_rasterize_nearest_resize_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mrnr_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned HALF_PERIOD  = 6;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 235;
  localparam int unsigned RAND_ITEMS   = PHASES * PHASE_ITEMS;
  localparam int unsigned PRESS_PHASE  = 6;
  localparam int unsigned PRESS_ITEMS  = 16;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned LIMIT_CYCLES = 5_000_000;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [PT_W-1:0]  pt_x;
    logic [PT_W-1:0]  pt_y;
    logic [PIX_W-1:0] pix_x;
    logic [PIX_W-1:0] pix_y;
  } mask_req_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask_value;
    logic              off_frame;
  } pixel_result_t;

  class mask_resize_scoreboard;
    logic [CFG_W-1:0] size_reg [4];
    bit               painted [int unsigned];
    pixel_result_t    pending_pixels [$];
    int unsigned      mismatches;

    function new();
      size_reg[REG_SRC_W] = RST_SRC_W;
      size_reg[REG_SRC_H] = RST_SRC_H;
      size_reg[REG_TGT_W] = RST_TGT_W;
      size_reg[REG_TGT_H] = RST_TGT_H;
      mismatches = 0;
    endfunction

    function int unsigned eff_size(logic [1:0] idx);
      int unsigned lim;
      lim = (idx == REG_SRC_W || idx == REG_TGT_W) ? MAX_WIDTH : MAX_HEIGHT;
      if (size_reg[idx] == '0) return 1;
      if (size_reg[idx] > lim) return lim;
      return size_reg[idx];
    endfunction

    // round(d*(s-1)/(t-1)), halves up
    function int unsigned nearest_src(int unsigned d, int unsigned s, int unsigned t);
      int unsigned q;
      if (s <= 1 || t <= 1) return 0;
      q = (2 * d * (s - 1) + (t - 1)) / (2 * (t - 1));
      if (q > s - 1) q = s - 1;
      return q;
    endfunction

    function void note_request(mask_req_t r);
      int unsigned sw, sh, tw, th, xs, ys;
      pixel_result_t res;
      sw = eff_size(REG_SRC_W);
      sh = eff_size(REG_SRC_H);
      tw = eff_size(REG_TGT_W);
      th = eff_size(REG_TGT_H);
      case (r.req)
        REQ_CLEAR: painted.delete();
        REQ_PAINT: begin
          if (r.pt_x < sw && r.pt_y < sh)
            painted[int'(r.pt_y) * MAX_WIDTH + int'(r.pt_x)] = 1'b1;
        end
        REQ_READ: begin
          res.mask_value = '0;
          res.off_frame  = 1'b0;
          if (r.pix_x >= tw || r.pix_y >= th) begin
            res.off_frame = 1'b1;
          end else begin
            xs = nearest_src(r.pix_x, sw, tw);
            ys = nearest_src(r.pix_y, sh, th);
            if (painted.exists(ys * MAX_WIDTH + xs)) res.mask_value = MASK_ON;
          end
          pending_pixels = {pending_pixels, res};
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(logic [MASK_W-1:0] mv, logic oof);
      pixel_result_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result mask_value=%0d out_of_frame=%0b", $realtime, mv, oof);
        return;
      end
      want = pending_pixels.pop_front();
      if (mv !== want.mask_value || oof !== want.off_frame) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: mismatch", $realtime);
          if (mv !== want.mask_value)
            $display("  mask_value   expected %0d got %0d", want.mask_value, mv);
          if (oof !== want.off_frame)
            $display("  out_of_frame expected %0b got %0b", want.off_frame, oof);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [PT_W-1:0]     in_point_x = '0;
  logic [PT_W-1:0]     in_point_y = '0;
  logic [PIX_W-1:0]    in_pixel_x = '0;
  logic [PIX_W-1:0]    in_pixel_y = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MASK_W-1:0]   out_mask_value;
  logic                out_out_of_frame;

  mask_resize_scoreboard sb;
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 68;
  int unsigned counted = 0;
  int unsigned clears_left = 6;
  bit          hold_request = 1'b0;

  mask_rasterize_nearest_resize_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mask_value   (out_mask_value),
    .out_out_of_frame (out_out_of_frame)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic mask_req_t make_req(logic [REQ_W-1:0] req, int unsigned px, int unsigned py,
                                         int unsigned dx, int unsigned dy);
    mask_req_t r;
    r.req   = req;
    r.pt_x  = PT_W'(px);
    r.pt_y  = PT_W'(py);
    r.pix_x = PIX_W'(dx);
    r.pix_y = PIX_W'(dy);
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(9))
      7: return CFG_W'($urandom);
      8, 9: begin
        case ($urandom_range(4))
          0: return 11'd0;
          1: return 11'd1;
          2: return 11'd2;
          3: return 11'd1024;
          default: return 11'd2047;
        endcase
      end
      default: return CFG_W'(1 + $urandom_range(11));
    endcase
  endfunction

  function automatic mask_req_t rand_request(input bit want_read);
    mask_req_t   r;
    int unsigned pick;
    r.req   = REQ_READ;
    r.pt_x  = PT_W'($urandom);
    r.pt_y  = PT_W'($urandom);
    r.pix_x = PIX_W'($urandom);
    r.pix_y = PIX_W'($urandom);
    pick = want_read ? 999 : $urandom_range(999);
    if (pick < 5 && clears_left > 0) begin
      r.req = REQ_CLEAR;
      clears_left--;
    end else if (pick < 25) begin
      r.req = REQ_UNUSED;
    end else if (pick < 520) begin
      r.req = REQ_PAINT;
      if ($urandom_range(9) < 8) begin
        r.pt_x = PT_W'($urandom_range(sb.eff_size(REG_SRC_W) - 1));
        r.pt_y = PT_W'($urandom_range(sb.eff_size(REG_SRC_H) - 1));
      end else if ($urandom_range(1) == 1) begin
        r.pt_x = PT_W'(sb.eff_size(REG_SRC_W));
      end
    end else if ($urandom_range(9) < 8) begin
      r.pix_x = PIX_W'($urandom_range(sb.eff_size(REG_TGT_W) - 1));
      r.pix_y = PIX_W'($urandom_range(sb.eff_size(REG_TGT_H) - 1));
    end else if ($urandom_range(1) == 1) begin
      r.pix_y = PIX_W'(sb.eff_size(REG_TGT_H));
    end
    return r;
  endfunction

  task automatic write_size(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~32'h7FF) | PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.size_reg[idx] = value;
  endtask

  task automatic push_request(input mask_req_t r);
    if (counted < RAND_ITEMS / 3) begin
      send_idle_pct = 32;
      recv_idle_pct = 68;
    end else if (counted < 2 * RAND_ITEMS / 3) begin
      send_idle_pct = 68;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= r.req;
    in_point_x  <= r.pt_x;
    in_point_y  <= r.pt_y;
    in_pixel_x  <= r.pix_x;
    in_pixel_y  <= r.pix_y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    if (r.req != REQ_UNUSED) counted++;
  endtask

  // drain results, then give paints and clear sweeps time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_mask_value, out_out_of_frame);
  end

  initial begin
    int unsigned base;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // full-size source, target width saturates to the maximum: identity
    write_size(REG_SRC_W, 11'd1024);
    write_size(REG_SRC_H, 11'd1024);
    write_size(REG_TGT_W, 11'd2047);
    write_size(REG_TGT_H, 11'd1024);
    push_request(make_req(REQ_PAINT, 0, 0, 0, 0));
    push_request(make_req(REQ_PAINT, 1023, 1023, 0, 0));
    push_request(make_req(REQ_PAINT, 1024, 7, 0, 0));
    push_request(make_req(REQ_PAINT, 4095, 4095, 1023, 1023));
    push_request(make_req(REQ_PAINT, 3, 1024, 0, 0));
    push_request(make_req(REQ_READ, 0, 0, 0, 0));
    push_request(make_req(REQ_READ, 4095, 4095, 1023, 1023));
    push_request(make_req(REQ_READ, 0, 0, 1023, 0));
    push_request(make_req(REQ_UNUSED, 4095, 4095, 1023, 1023));
    push_request(make_req(REQ_READ, 0, 0, 0, 1023));
    push_request(make_req(REQ_CLEAR, 4095, 4095, 1023, 1023));
    push_request(make_req(REQ_READ, 0, 0, 0, 0));
    settle();

    // zero width reads as one, single-row target
    write_size(REG_SRC_W, 11'd0);
    write_size(REG_SRC_H, 11'd3);
    write_size(REG_TGT_W, 11'd5);
    write_size(REG_TGT_H, 11'd1);
    push_request(make_req(REQ_PAINT, 0, 0, 0, 0));
    push_request(make_req(REQ_PAINT, 1, 0, 0, 0));
    push_request(make_req(REQ_PAINT, 0, 2, 0, 0));
    push_request(make_req(REQ_READ, 0, 0, 4, 0));
    push_request(make_req(REQ_READ, 0, 0, 0, 1));
    push_request(make_req(REQ_READ, 0, 0, 5, 0));
    push_request(make_req(REQ_READ, 0, 0, 1023, 1023));
    settle();

    // 2 -> 3 upscale, middle pixel rounds half up
    write_size(REG_SRC_W, 11'd2);
    write_size(REG_SRC_H, 11'd2);
    write_size(REG_TGT_W, 11'd3);
    write_size(REG_TGT_H, 11'd3);
    push_request(make_req(REQ_PAINT, 1, 1, 0, 0));
    push_request(make_req(REQ_READ, 0, 0, 1, 1));
    push_request(make_req(REQ_READ, 0, 0, 1, 0));
    push_request(make_req(REQ_READ, 0, 0, 2, 2));

    counted = 0;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_size(REG_SRC_W, pick_size());
      write_size(REG_SRC_H, pick_size());
      write_size(REG_TGT_W, pick_size());
      write_size(REG_TGT_H, pick_size());
      base = counted;
      if (p == PRESS_PHASE) begin
        hold_request = 1'b1;
        for (int k = 0; k < PRESS_ITEMS; k++) push_request(rand_request(1'b1));
      end
      while (counted < base + PHASE_ITEMS) push_request(rand_request(1'b0));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mrnr_pkg.sv
rtl/mrnr_ram.sv
rtl/mrnr_div.sv
rtl/mask_rasterize_nearest_resize_unit.sv
bench/tb_mask_rasterize_nearest_resize_unit.sv
